[hdl/ipv4_forward_route_lookup_macros.svh]
// Assertion helpers for the route lookup block.
`ifndef IPV4_FORWARD_ROUTE_LOOKUP_MACROS_SVH
`define IPV4_FORWARD_ROUTE_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define IFRL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ifrl assertion failed");

// Implication with a fixed delay in cycles.
`define IFRL_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error("ifrl delayed assertion failed");

`endif

[hdl/ifrl_pkg.sv]
package ifrl_pkg;

  typedef enum logic [2:0] {
    VERD_LOCAL     = 3'd0,
    VERD_FORWARD   = 3'd1,
    VERD_BAD_VER   = 3'd2,
    VERD_BAD_LEN   = 3'd3,
    VERD_TTL       = 3'd4,
    VERD_NO_ROUTE  = 3'd5
  } verdict_e;

  localparam logic       CMD_ADD      = 1'b0;
  localparam logic       CMD_HDR      = 1'b1;
  localparam logic [3:0] IDX_VER      = 4'd0;
  localparam logic [3:0] IDX_TTL      = 4'd2;
  localparam logic [3:0] IDX_DST      = 4'd4;
  localparam logic [3:0] WIDX_MAX     = 4'd15;
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam logic [3:0] IHL_MIN      = 4'd5;

  typedef struct packed {
    logic [31:0] dest;
    logic [5:0]  prefix_len;
    logic [31:0] hop;
  } add_t;

  typedef struct packed {
    logic        vld;
    logic        lookup;
    logic        found;
    verdict_e    verdict;
    logic [31:0] dest;
    logic [31:0] hop;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } tok_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = '0;
    end else if (len >= 6'd32) begin
      m = '1;
    end else begin
      m = ~(32'hffff_ffff >> len);
    end
    return m;
  endfunction

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[hdl/ipv4_forward_route_lookup.sv]
// A header word with word_last gives its result after passing through the registered stages
// in order: one parse stage, one stage per route cell, one result stage.
// Throughput: one word per cycle; busy stays low and route adds go straight into the next free route cell.
// The result strobe done_o lasts one cycle and cannot be held off by the receiver.
// Reset: asynchronous, active low; clears the route count, packet assembly, local address
// and the lookup pipeline. Route entries are left unwritten.
module ipv4_forward_route_lookup #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [31:0] route_dest_i,
  input  logic [5:0]  route_prefix_len_i,
  input  logic [31:0] route_next_hop_i,
  input  logic [31:0] header_word_i,
  input  logic        word_last_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  verdict_o,
  output logic [31:0] next_hop_o,
  output logic [7:0]  new_ttl_o,
  output logic [15:0] new_checksum_o
);

  localparam int CW = $clog2(ROUTE_ENTRIES + 1);

  logic            acc, add_acc, hdr_acc;
  logic [CW-1:0]   ent_cnt_q, ent_cnt_d;
  logic [31:0]     local_q, local_d;
  ifrl_pkg::add_t  add;
  ifrl_pkg::tok_t  tok [ROUTE_ENTRIES+1];
  logic [CW-1:0]   cnt [ROUTE_ENTRIES+1];
  ifrl_pkg::tok_t  fin;

  logic            done_q, done_d;
  logic [2:0]      verdict_q, verdict_d;
  logic [31:0]     hop_q, hop_d;
  logic [7:0]      ttl_q, ttl_d;
  logic [15:0]     csum_q, csum_d;

  assign busy    = 1'b0;
  assign acc     = start && !busy;
  assign add_acc = acc && (command_i == ifrl_pkg::CMD_ADD);
  assign hdr_acc = acc && (command_i == ifrl_pkg::CMD_HDR);

  assign add.dest       = route_dest_i;
  assign add.prefix_len = route_prefix_len_i;
  assign add.hop        = route_next_hop_i;

  always_comb begin
    ent_cnt_d = ent_cnt_q;
    if (add_acc && (ent_cnt_q < CW'(ROUTE_ENTRIES))) begin
      ent_cnt_d = ent_cnt_q + CW'(1);
    end
    local_d = cfg_we_i ? cfg_wdata_i : local_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_cnt_q <= '0;
      local_q   <= '0;
    end else begin
      ent_cnt_q <= ent_cnt_d;
      local_q   <= local_d;
    end
  end

  ifrl_hdr #(
    .CW (CW)
  ) u_hdr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hdr_we_i (hdr_acc),
    .word_i   (header_word_i),
    .last_i   (word_last_i),
    .local_i  (local_q),
    .cnt_i    (ent_cnt_q),
    .tok_o    (tok[0]),
    .cnt_o    (cnt[0])
  );

  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    ifrl_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sel_i  (add_acc && (ent_cnt_q == CW'(g))),
      .add_i  (add),
      .cnt_i  (cnt[g]),
      .tok_i  (tok[g]),
      .cnt_o  (cnt[g+1]),
      .tok_o  (tok[g+1])
    );
  end

  assign fin = tok[ROUTE_ENTRIES];

  always_comb begin
    done_d    = fin.vld;
    verdict_d = fin.verdict;
    hop_d     = '0;
    ttl_d     = fin.ttl;
    csum_d    = '0;
    if (fin.lookup) begin
      if (fin.found) begin
        verdict_d = ifrl_pkg::VERD_FORWARD;
        hop_d     = fin.hop;
        ttl_d     = fin.ttl - 8'd1;
        csum_d    = fin.csum;
      end else begin
        verdict_d = ifrl_pkg::VERD_NO_ROUTE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    hop_q     <= hop_d;
    ttl_q     <= ttl_d;
    csum_q    <= csum_d;
  end

  assign done_o         = done_q;
  assign verdict_o      = verdict_q;
  assign next_hop_o     = hop_q;
  assign new_ttl_o      = ttl_q;
  assign new_checksum_o = csum_q;

endmodule

[hdl/ifrl_hdr.sv]
module ifrl_hdr #(
  parameter int CW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hdr_we_i,
  input  logic [31:0]         word_i,
  input  logic                last_i,
  input  logic [31:0]         local_i,
  input  logic [CW-1:0]       cnt_i,
  output ifrl_pkg::tok_t      tok_o,
  output logic [CW-1:0]       cnt_o
);

  logic [3:0]     widx_q, widx_d, widx_n;
  logic [15:0]    sum_q, sum_d, sum_n;
  logic [15:0]    fwf_q, fwf_d, fwf_n;
  logic [31:0]    dst_q, dst_d, dst_n;
  logic [15:0]    hi, lo;
  ifrl_pkg::tok_t tok_q, tok_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  always_comb begin
    if (widx_q == ifrl_pkg::IDX_VER) begin
      fwf_n = {word_i[31:24], 8'h00};
    end else if (widx_q == ifrl_pkg::IDX_TTL) begin
      fwf_n = {fwf_q[15:8], word_i[31:24]};
    end else begin
      fwf_n = fwf_q;
    end
    dst_n = (widx_q == ifrl_pkg::IDX_DST) ? word_i : dst_q;

    if (widx_q == ifrl_pkg::IDX_TTL) begin
      hi = {word_i[31:24] - 8'd1, word_i[23:16]};
      lo = '0;
    end else begin
      hi = word_i[31:16];
      lo = word_i[15:0];
    end
    sum_n = (widx_q < fwf_n[11:8]) ?
            ifrl_pkg::ones_add(ifrl_pkg::ones_add(sum_q, hi), lo) : sum_q;
    widx_n = (widx_q == ifrl_pkg::WIDX_MAX) ? widx_q : widx_q + 4'd1;

    widx_d = widx_q;
    sum_d  = sum_q;
    fwf_d  = fwf_q;
    dst_d  = dst_q;
    cnt_d  = cnt_i;

    tok_d         = '0;
    tok_d.verdict = ifrl_pkg::VERD_LOCAL;
    tok_d.dest    = dst_n;
    tok_d.ttl     = fwf_n[7:0];
    tok_d.csum    = ~sum_n;
    if (fwf_n[15:12] != ifrl_pkg::IPV4_VERSION) begin
      tok_d.verdict = ifrl_pkg::VERD_BAD_VER;
    end else if (fwf_n[11:8] < ifrl_pkg::IHL_MIN) begin
      tok_d.verdict = ifrl_pkg::VERD_BAD_LEN;
    end else if (fwf_n[7:0] == 8'd0) begin
      tok_d.verdict = ifrl_pkg::VERD_TTL;
    end else if (dst_n != local_i) begin
      tok_d.lookup = 1'b1;
    end

    if (hdr_we_i) begin
      if (last_i) begin
        tok_d.vld = 1'b1;
        widx_d    = '0;
        sum_d     = '0;
        fwf_d     = '0;
        dst_d     = '0;
      end else begin
        widx_d = widx_n;
        sum_d  = sum_n;
        fwf_d  = fwf_n;
        dst_d  = dst_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      sum_q  <= '0;
      fwf_q  <= '0;
      dst_q  <= '0;
      tok_q  <= '0;
    end else begin
      widx_q <= widx_d;
      sum_q  <= sum_d;
      fwf_q  <= fwf_d;
      dst_q  <= dst_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

[hdl/ifrl_cell.sv]
module ifrl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sel_i,
  input  ifrl_pkg::add_t add_i,
  input  logic [CW-1:0]  cnt_i,
  input  ifrl_pkg::tok_t tok_i,
  output logic [CW-1:0]  cnt_o,
  output ifrl_pkg::tok_t tok_o
);

  logic [31:0]    mask_q, mdst_q, hop_q;
  logic [31:0]    mask_d, mdst_d, hop_d;
  logic [CW-1:0]  cnt_q;
  ifrl_pkg::tok_t tok_q, tok_d;
  logic           hit;

  always_comb begin
    mask_d = mask_q;
    mdst_d = mdst_q;
    hop_d  = hop_q;
    if (sel_i) begin
      mask_d = ifrl_pkg::prefix_mask(add_i.prefix_len);
      mdst_d = add_i.dest & ifrl_pkg::prefix_mask(add_i.prefix_len);
      hop_d  = add_i.hop;
    end
  end

  assign hit = tok_i.lookup && !tok_i.found && (CW'(IDX) < cnt_i) &&
               ((tok_i.dest & mask_q) == mdst_q);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.hop   = hop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    mdst_q <= mdst_d;
    hop_q  <= hop_d;
    cnt_q  <= cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

[hdl/ifrl_chk.sv]
`include "ipv4_forward_route_lookup_macros.svh"

module ifrl_chk #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        command_i,
  input  logic        word_last_i,
  input  logic        done_o,
  input  logic [2:0]  verdict_o,
  input  logic [31:0] next_hop_o,
  input  logic [15:0] new_checksum_o
);

  localparam int LAT = ROUTE_ENTRIES + 2;

  logic pkt_end;
  logic drop_res;
  logic zero_res;

  assign pkt_end = start && !busy && (command_i == ifrl_pkg::CMD_HDR) && word_last_i;

  assign drop_res = done_o && (verdict_o != ifrl_pkg::VERD_FORWARD);
  assign zero_res = (next_hop_o == 32'd0) && (new_checksum_o == 16'd0);

  `IFRL_ASSERT_DLY(a_result_follows, pkt_end, LAT, done_o)

  `IFRL_ASSERT_IMPL(a_no_spurious, done_o, $past(pkt_end, LAT))

  `IFRL_ASSERT_IMPL(a_drop_clears, drop_res, zero_res)

endmodule

bind ipv4_forward_route_lookup ifrl_chk #(
  .ROUTE_ENTRIES (ROUTE_ENTRIES)
) u_ifrl_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .word_last_i    (word_last_i),
  .done_o         (done_o),
  .verdict_o      (verdict_o),
  .next_hop_o     (next_hop_o),
  .new_checksum_o (new_checksum_o)
);
